### hdl/vtpy_pkg.sv
package vtpy_pkg;

   // Widths of the coordinate and angle data paths.
   localparam int COORD_W = 24;
   localparam int DIFF_W  = 27;
   localparam int EYE_W   = 20;
   localparam int PITCH_W = 15;
   localparam int YAW_W   = 16;

   // CORDIC operands carry the differences scaled by 2^30, plus growth headroom.
   localparam int PRESCALE_SH = 30;
   localparam int CORD_W      = 64;
   localparam int ANG_W       = 34;
   localparam int TAB_LEN     = 32;

   // Gain correction for the elevation pass, Q30.
   localparam logic [31:0] K_Q30 = 32'd1768195363;

   // Clamp limits in hundredths of a degree.
   localparam int YAW_LIMIT   = 18000;
   localparam int PITCH_LIMIT = 8900;

   // Scale factor from binary angle units to centidegrees.
   localparam logic [15:0] CENTIDEG_PER_TURN = 16'd36000;

   typedef logic signed [CORD_W-1:0] cord_type;
   typedef logic signed [ANG_W-1:0]  ang_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] local_x;
      logic signed [COORD_W-1:0] local_y;
      logic signed [COORD_W-1:0] local_z;
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic signed [COORD_W-1:0] target_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [PITCH_W-1:0] pitch_centideg;
      logic signed [YAW_W-1:0]   yaw_centideg;
      logic                      zero_vector;
   } rsp_payload_type;

   // Arctangent of 2^-i in units of 2^32 per full turn, rounded to nearest.
   function automatic ang_type atan_tab(input logic [4:0] idx);
      ang_type r;
      case (idx)
         5'd0:  r = 34'sh020000000;
         5'd1:  r = 34'sh012E4051E;
         5'd2:  r = 34'sh009FB385B;
         5'd3:  r = 34'sh0051111D4;
         5'd4:  r = 34'sh0028B0D43;
         5'd5:  r = 34'sh00145D7E1;
         5'd6:  r = 34'sh000A2F61E;
         5'd7:  r = 34'sh000517C55;
         5'd8:  r = 34'sh00028BE53;
         5'd9:  r = 34'sh000145F2F;
         5'd10: r = 34'sh0000A2F98;
         5'd11: r = 34'sh0000517CC;
         5'd12: r = 34'sh000028BE6;
         5'd13: r = 34'sh0000145F3;
         5'd14: r = 34'sh00000A2FA;
         5'd15: r = 34'sh00000517D;
         5'd16: r = 34'sh0000028BE;
         5'd17: r = 34'sh00000145F;
         5'd18: r = 34'sh000000A30;
         5'd19: r = 34'sh000000518;
         5'd20: r = 34'sh00000028C;
         5'd21: r = 34'sh000000146;
         5'd22: r = 34'sh0000000A3;
         5'd23: r = 34'sh000000051;
         5'd24: r = 34'sh000000029;
         5'd25: r = 34'sh000000014;
         5'd26: r = 34'sh00000000A;
         5'd27: r = 34'sh000000005;
         5'd28: r = 34'sh000000003;
         5'd29: r = 34'sh000000001;
         5'd30: r = 34'sh000000001;
         default: r = '0;
      endcase
      return r;
   endfunction

   // Centidegrees from a binary angle: round half away from zero, then clamp.
   function automatic logic signed [YAW_W:0] to_centideg(input ang_type ang,
                                                         input int limit);
      logic [ANG_W-1:0] mag;
      logic [ANG_W+15:0] prod;
      logic [17:0] cd;
      logic signed [YAW_W:0] res;
      mag  = ang[ANG_W-1] ? ANG_W'(-ang) : ANG_W'(ang);
      prod = (ANG_W+16)'(mag) * (ANG_W+16)'(CENTIDEG_PER_TURN)
             + (ANG_W+16)'(64'h80000000);
      cd   = 18'(prod >> 32);
      if (cd > 18'(limit)) cd = 18'(limit);
      res  = ang[ANG_W-1] ? -(YAW_W+1)'(cd) : (YAW_W+1)'(cd);
      return res;
   endfunction

endpackage

### hdl/vtpy_if.sv
interface vtpy_req_if;
   logic                     valid;
   logic                     ready;
   vtpy_pkg::req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface vtpy_rsp_if;
   logic                     valid;
   logic                     ready;
   vtpy_pkg::rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface vtpy_csr_if;
   logic                        valid;
   logic                        ready;
   logic [vtpy_pkg::EYE_W-1:0]  data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hdl/vtpy_cordic_stage.sv
// One registered CORDIC vectoring micro-rotation with a fixed shift.
module vtpy_cordic_stage #(
   parameter int SHIFT = 0,
   parameter int SIDE_W = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  logic                   valid_in,
   input  vtpy_pkg::cord_type     x_in,
   input  vtpy_pkg::cord_type     y_in,
   input  vtpy_pkg::ang_type      ang_in,
   input  logic [SIDE_W-1:0]      side_in,
   output logic                   valid_out,
   output vtpy_pkg::cord_type     x_out,
   output vtpy_pkg::cord_type     y_out,
   output vtpy_pkg::ang_type      ang_out,
   output logic [SIDE_W-1:0]      side_out
);

   logic               valid_ff;
   vtpy_pkg::cord_type x_ff, x_in_w, y_ff, y_in_w;
   vtpy_pkg::ang_type  ang_ff, ang_in_w;
   logic [SIDE_W-1:0]  side_ff;
   vtpy_pkg::ang_type  step;

   assign step = vtpy_pkg::atan_tab(5'(SHIFT));

   // Rotate toward the x axis; arithmetic shifts floor.
   always_comb begin
      if (!y_in[vtpy_pkg::CORD_W-1]) begin
         x_in_w   = x_in + (y_in >>> SHIFT);
         y_in_w   = y_in - (x_in >>> SHIFT);
         ang_in_w = ang_in + step;
      end else begin
         x_in_w   = x_in - (y_in >>> SHIFT);
         y_in_w   = y_in + (x_in >>> SHIFT);
         ang_in_w = ang_in - step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in_w;
         y_ff    <= y_in_w;
         ang_ff  <= ang_in_w;
         side_ff <= side_in;
      end
   end

   assign valid_out = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign ang_out   = ang_ff;
   assign side_out  = side_ff;

endmodule

### hdl/vtpy_cordic_pipe.sv
// Chain of registered micro-rotations; side data travels alongside.
module vtpy_cordic_pipe #(
   parameter int ITERATIONS = 20,
   parameter int SIDE_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               valid_in,
   input  vtpy_pkg::cord_type x_in,
   input  vtpy_pkg::cord_type y_in,
   input  vtpy_pkg::ang_type  ang_in,
   input  logic [SIDE_W-1:0]  side_in,
   output logic               valid_out,
   output vtpy_pkg::cord_type x_out,
   output vtpy_pkg::ang_type  ang_out,
   output logic [SIDE_W-1:0]  side_out
);

   logic               v [ITERATIONS+1];
   vtpy_pkg::cord_type xs [ITERATIONS+1];
   vtpy_pkg::cord_type ys [ITERATIONS+1];
   vtpy_pkg::ang_type  as [ITERATIONS+1];
   logic [SIDE_W-1:0]  ss [ITERATIONS+1];

   assign v[0]  = valid_in;
   assign xs[0] = x_in;
   assign ys[0] = y_in;
   assign as[0] = ang_in;
   assign ss[0] = side_in;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_stage
      vtpy_cordic_stage #(.SHIFT(i), .SIDE_W(SIDE_W)) u_stage (
         .clock(clock), .reset(reset), .advance(advance),
         .valid_in(v[i]), .x_in(xs[i]), .y_in(ys[i]), .ang_in(as[i]), .side_in(ss[i]),
         .valid_out(v[i+1]), .x_out(xs[i+1]), .y_out(ys[i+1]), .ang_out(as[i+1]),
         .side_out(ss[i+1])
      );
   end

   assign valid_out = v[ITERATIONS];
   assign x_out     = xs[ITERATIONS];
   assign ang_out   = as[ITERATIONS];
   assign side_out  = ss[ITERATIONS];

endmodule

### hdl/vector_to_pitch_yaw.sv
// Channel | Direction | Contents
// req     | in        | observer and target positions, signed Q16.8
// rsp     | out       | pitch and yaw in centidegrees, zero-vector flag
// csr     | in        | eye height, unsigned Q12.8, always ready
//
// One transaction may enter every cycle unless rsp stalls. The pipeline consists of the
// difference stage, the yaw CORDIC chain, the dz gain multiply, the pitch CORDIC chain,
// and the centidegree conversion register. The whole pipeline advances together, so a
// stall on rsp holds every stage. Reset clears the valid bits and sets eye height to 64.0.
module vector_to_pitch_yaw #(
   parameter int CORDIC_ITERATIONS = 20
) (
   input  logic      clock,
   input  logic      reset,
   vtpy_req_if.sink   req,
   vtpy_rsp_if.source rsp,
   vtpy_csr_if.sink   csr
);

   localparam int SIDE_W = vtpy_pkg::DIFF_W + 2;

   logic [vtpy_pkg::EYE_W-1:0] eye_ff;
   logic advance;

   // Stage 0: differences and quadrant fold.
   logic                         s0_valid_ff;
   vtpy_pkg::cord_type           s0_x_ff, s0_y_ff;
   vtpy_pkg::ang_type            s0_ang_ff;
   logic signed [vtpy_pkg::DIFF_W-1:0] s0_dz_ff;
   logic                         s0_zero_ff, s0_vert_ff;

   logic signed [vtpy_pkg::DIFF_W-1:0] dx_w, dy_w, dz_w;
   vtpy_pkg::cord_type           x0_w, y0_w;
   vtpy_pkg::ang_type            a0_w;

   // Yaw chain outputs.
   logic                         yv;
   vtpy_pkg::cord_type           yx;
   vtpy_pkg::ang_type            ya;
   logic [SIDE_W-1:0]            yside;

   // Stage M: gain multiply of dz and yaw conversion.
   logic                         m_valid_ff;
   vtpy_pkg::cord_type           m_h_ff, m_z_ff;
   logic signed [vtpy_pkg::YAW_W-1:0] m_yaw_ff;
   logic                         m_zero_ff;

   // Pitch chain outputs.
   logic                         pv;
   vtpy_pkg::cord_type           px;
   vtpy_pkg::ang_type            pa;
   logic [vtpy_pkg::YAW_W:0]     pside;

   // Output register.
   logic                         o_valid_ff;
   vtpy_pkg::rsp_payload_type    o_ff;

   assign advance   = !o_valid_ff || rsp.ready;
   assign req.ready = advance;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eye_ff <= vtpy_pkg::EYE_W'(16384);
      end else if (csr.valid) begin
         eye_ff <= csr.data;
      end
   end

   // Difference vector and pre-rotation into the right half plane.
   always_comb begin
      dx_w = vtpy_pkg::DIFF_W'(req.payload.target_x) - vtpy_pkg::DIFF_W'(req.payload.local_x);
      dy_w = vtpy_pkg::DIFF_W'(req.payload.target_y) - vtpy_pkg::DIFF_W'(req.payload.local_y);
      dz_w = vtpy_pkg::DIFF_W'(req.payload.target_z) - vtpy_pkg::DIFF_W'(req.payload.local_z)
             - vtpy_pkg::DIFF_W'({1'b0, eye_ff});
      x0_w = vtpy_pkg::CORD_W'(dx_w) <<< vtpy_pkg::PRESCALE_SH;
      y0_w = vtpy_pkg::CORD_W'(dy_w) <<< vtpy_pkg::PRESCALE_SH;
      a0_w = '0;
      if (dx_w[vtpy_pkg::DIFF_W-1]) begin
         x0_w = -x0_w;
         y0_w = -y0_w;
         a0_w = dy_w[vtpy_pkg::DIFF_W-1] ? -(vtpy_pkg::ANG_W'(64'h80000000))
                                          : vtpy_pkg::ANG_W'(64'h80000000);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_x_ff    <= x0_w;
         s0_y_ff    <= y0_w;
         s0_ang_ff  <= a0_w;
         s0_dz_ff   <= dz_w;
         s0_vert_ff <= (dx_w == '0) && (dy_w == '0);
         s0_zero_ff <= (dx_w == '0) && (dy_w == '0) && (dz_w == '0);
      end
   end

   vtpy_cordic_pipe #(.ITERATIONS(CORDIC_ITERATIONS), .SIDE_W(SIDE_W)) u_yaw (
      .clock(clock), .reset(reset), .advance(advance),
      .valid_in(s0_valid_ff), .x_in(s0_x_ff), .y_in(s0_y_ff), .ang_in(s0_ang_ff),
      .side_in({s0_dz_ff, s0_vert_ff, s0_zero_ff}),
      .valid_out(yv), .x_out(yx), .ang_out(ya), .side_out(yside)
   );

   // Scale dz by the CORDIC gain; a vertical vector has zero horizontal length and yaw.
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (advance) begin
         m_valid_ff <= yv;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_h_ff    <= yside[1] ? '0 : yx;
         m_z_ff    <= vtpy_pkg::CORD_W'(signed'(yside[SIDE_W-1:2]))
                      * signed'({1'b0, vtpy_pkg::K_Q30});
         m_yaw_ff  <= (yside[1] || yside[0]) ? '0 :
                      vtpy_pkg::YAW_W'(vtpy_pkg::to_centideg(ya, vtpy_pkg::YAW_LIMIT));
         m_zero_ff <= yside[0];
      end
   end

   vtpy_cordic_pipe #(.ITERATIONS(CORDIC_ITERATIONS), .SIDE_W(vtpy_pkg::YAW_W+1)) u_pitch (
      .clock(clock), .reset(reset), .advance(advance),
      .valid_in(m_valid_ff), .x_in(m_h_ff), .y_in(m_z_ff), .ang_in('0),
      .side_in({m_yaw_ff, m_zero_ff}),
      .valid_out(pv), .x_out(px), .ang_out(pa), .side_out(pside)
   );

   // Convert negated elevation and present the result.
   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (advance) begin
         o_valid_ff <= pv;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         o_ff.pitch_centideg <= pside[0] ? '0 :
            vtpy_pkg::PITCH_W'(vtpy_pkg::to_centideg(-pa, vtpy_pkg::PITCH_LIMIT));
         o_ff.yaw_centideg   <= pside[vtpy_pkg::YAW_W:1];
         o_ff.zero_vector    <= pside[0] && (px == px);
      end
   end

   assign rsp.valid   = o_valid_ff;
   assign rsp.payload = o_ff;

endmodule
